[hw/rtl/grma_pkg.sv]
// ----------------------------------------------------------------------------
// grma_pkg
// shared types and constants of the gravity-removed motion accel block
// ----------------------------------------------------------------------------
package grma_pkg;

  localparam int unsigned AlphaW     = 17;
  localparam int unsigned GravW      = 21;
  localparam int unsigned QuatW      = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned AccW       = 72;
  localparam int unsigned PaddrW     = 3;
  localparam logic [AlphaW-1:0] AlphaOne   = 17'd65536;
  localparam logic [GravW-1:0]  GravReset  = 21'd642908;
  localparam logic [PaddrW-1:0] AddrAlpha  = 3'd0;
  localparam logic [PaddrW-1:0] AddrGrav   = 3'd4;

  typedef logic signed [DataW-1:0] data_t;

  function automatic data_t sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(signed'(33'sh0_7FFF_FFFF));
    lo = -hi - AccW'(1);
    if (v > hi) return data_t'(hi);
    if (v < lo) return data_t'(lo);
    return data_t'(v);
  endfunction

endpackage

[hw/rtl/grma_stream_if.sv]
// ----------------------------------------------------------------------------
// grma_stream_if
// valid/ready channel carrying a payload struct
// ----------------------------------------------------------------------------
interface grma_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/gravity_removed_motion_accel_top.sv]
// ----------------------------------------------------------------------------
// gravity_removed_motion_accel_top
// gravity removal, low-pass filter and earth-frame rotation of imu samples
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A sequencer drives a single
// shared 36x33 signed multiply-accumulate unit through 36 steps (18 for the
// rotation matrix, 3 for body gravity, 6 for the filter, 9 for the earth
// rotation); the input is not ready meanwhile. The result is held on the
// output until it is taken, and the next item can be accepted in the cycle
// after that, so a new item is never taken before the last result has gone.
// Configuration goes through the apb port: filter_alpha at 0x0,
// gravity_level at 0x4.
module gravity_removed_motion_accel_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  grma_stream_if.sink                in_if,
  grma_stream_if.source              out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [grma_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import grma_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMat  = 5'b00010,
    StGrav = 5'b00100,
    StFilt = 5'b01000,
    StRot  = 5'b10000
  } state_e;

  state_e state_q;
  logic [AlphaW-1:0] alpha_q;
  logic [GravW-1:0]  grav_q;
  logic signed [QuatW-1:0] q_q [4];
  data_t acc_in_q [3];
  logic signed [35:0] r_q [9];
  data_t s_q [3];
  data_t e_q [3];
  logic signed [AccW-1:0] acc_q;
  logic [3:0] idx_q;   // matrix entry, axis or row
  logic [2:0] sub_q;   // term within entry, axis or row
  logic busy_out_q;

  // apb
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == AddrAlpha) prdata = 32'(alpha_q);
    else if (paddr == AddrGrav) prdata = 32'(grav_q);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= AlphaOne;
      grav_q  <= GravReset;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrAlpha) alpha_q <= pwdata[AlphaW-1:0];
      else if (paddr == AddrGrav) grav_q <= pwdata[GravW-1:0];
    end
  end

  logic [AlphaW-1:0] a_eff;
  assign a_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;

  // shared multiplier operands
  logic signed [35:0] op_a;
  logic signed [32:0] op_b;
  logic signed [68:0] prod;
  logic signed [QuatW-1:0] qa, qb, qc, qd;
  logic neg_term;
  logic [1:0] ri, rj;
  data_t s_sel;
  logic signed [32:0] gb;
  logic signed [33:0] dif;

  // matrix entries: idx 0..8 row-major, sub 0/1 two products
  always_comb begin
    qa = '0; qb = '0; neg_term = 1'b0;
    qc = '0; qd = '0;
    case (idx_q)
      4'd0: begin qa = q_q[2]; qb = q_q[2]; qc = q_q[3]; qd = q_q[3]; end
      4'd1: begin qa = q_q[1]; qb = q_q[2]; qc = q_q[0]; qd = q_q[3]; neg_term = 1'b1; end
      4'd2: begin qa = q_q[1]; qb = q_q[3]; qc = q_q[0]; qd = q_q[2]; end
      4'd3: begin qa = q_q[1]; qb = q_q[2]; qc = q_q[0]; qd = q_q[3]; end
      4'd4: begin qa = q_q[1]; qb = q_q[1]; qc = q_q[3]; qd = q_q[3]; end
      4'd5: begin qa = q_q[2]; qb = q_q[3]; qc = q_q[0]; qd = q_q[1]; neg_term = 1'b1; end
      4'd6: begin qa = q_q[1]; qb = q_q[3]; qc = q_q[0]; qd = q_q[2]; neg_term = 1'b1; end
      4'd7: begin qa = q_q[2]; qb = q_q[3]; qc = q_q[0]; qd = q_q[1]; end
      4'd8: begin qa = q_q[1]; qb = q_q[1]; qc = q_q[2]; qd = q_q[2]; end
      default: ;
    endcase
  end

  assign ri = idx_q[3:2];
  assign rj = sub_q[1:0];
  always_comb begin
    s_sel = s_q[0];
    case (rj)
      2'd1: s_sel = s_q[1];
      2'd2: s_sel = s_q[2];
      default: s_sel = s_q[0];
    endcase
  end

  logic [3:0] rid;
  assign rid = 4'(ri * 3) + 4'(rj);
  logic [3:0] gid;
  assign gid = 4'd6 + idx_q;

  assign gb = 33'(acc_q >>> 28);
  always_comb begin
    dif = 34'(acc_in_q[idx_q[1:0]]) - 34'(gb);
  end

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_q)
      StMat: begin
        if (sub_q[0]) begin op_a = 36'(qc); op_b = 33'(qd); end
        else begin op_a = 36'(qa); op_b = 33'(qb); end
      end
      StGrav: begin
        op_a = r_q[gid];
        op_b = 33'(signed'({1'b0, grav_q}));
      end
      StFilt: begin
        if (sub_q[0]) begin
          op_a = 36'(s_q[idx_q[1:0]]);
          op_b = 33'(signed'({1'b0, AlphaOne - a_eff}));
        end else begin
          op_a = 36'(dif);
          op_b = 33'(signed'({1'b0, a_eff}));
        end
      end
      StRot: begin
        op_a = r_q[rid];
        op_b = 33'(s_sel);
      end
      default: ;
    endcase
  end
  assign prod = op_a * op_b;

  logic signed [AccW-1:0] prod_x;
  logic signed [AccW-1:0] mat_term;
  assign prod_x = AccW'(prod);
  assign mat_term = (sub_q[0] && neg_term) ? -prod_x : prod_x;

  logic diag;
  assign diag = (idx_q == 4'd0) || (idx_q == 4'd4) || (idx_q == 4'd8);

  logic in_fire, out_fire;
  assign in_if.ready = (state_q == StIdle) && !busy_out_q;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_if.valid = busy_out_q;
  assign out_fire = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      sub_q <= '0;
      busy_out_q <= 1'b0;
      for (int i = 0; i < 3; i++) s_q[i] <= '0;
      acc_q <= '0;
    end else begin
      if (out_fire) busy_out_q <= 1'b0;
      case (state_q)
        StIdle: if (in_fire) begin
          q_q[0] <= in_if.data.quat_w;
          q_q[1] <= in_if.data.quat_x;
          q_q[2] <= in_if.data.quat_y;
          q_q[3] <= in_if.data.quat_z;
          acc_in_q[0] <= in_if.data.accel_x;
          acc_in_q[1] <= in_if.data.accel_y;
          acc_in_q[2] <= in_if.data.accel_z;
          idx_q <= '0; sub_q <= '0; acc_q <= '0;
          state_q <= StMat;
        end
        StMat: begin
          if (!sub_q[0]) begin
            acc_q <= mat_term;
            sub_q <= 3'd1;
          end else begin
            if (diag) r_q[idx_q] <= 36'(AccW'(1 << 28) - ((acc_q + mat_term) <<< 1));
            else r_q[idx_q] <= 36'((acc_q + mat_term) <<< 1);
            sub_q <= '0;
            if (idx_q == 4'd8) begin idx_q <= '0; state_q <= StGrav; end
            else idx_q <= idx_q + 4'd1;
          end
        end
        // StGrav: gravity product; StFilt sub 0: alpha*d; sub 1: (1-alpha)*s, store
        StGrav: begin
          acc_q <= prod_x + AccW'(1 << 27);
          sub_q <= '0;
          state_q <= StFilt;
        end
        StFilt: begin
          if (!sub_q[0]) begin
            acc_q <= prod_x;
            sub_q <= 3'd1;
          end else begin
            s_q[idx_q[1:0]] <= sat32((acc_q + prod_x + AccW'(32768)) >>> 16);
            sub_q <= '0;
            if (idx_q == 4'd2) begin idx_q <= '0; acc_q <= '0; state_q <= StRot; end
            else begin idx_q <= idx_q + 4'd1; state_q <= StGrav; end
          end
        end
        StRot: begin
          if (sub_q == 3'd2) begin
            e_q[ri] <= sat32((acc_q + prod_x + AccW'(1 << 27)) >>> 28);
            acc_q <= '0;
            sub_q <= '0;
            if (ri == 2'd2) begin
              idx_q <= '0;
              busy_out_q <= 1'b1;
              state_q <= StIdle;
            end else idx_q <= idx_q + 4'd4;
          end else begin
            acc_q <= acc_q + prod_x;
            sub_q <= sub_q + 3'd1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.data.body_motion_x  = s_q[0];
  assign out_if.data.body_motion_y  = s_q[1];
  assign out_if.data.body_motion_z  = s_q[2];
  assign out_if.data.earth_motion_x = e_q[0];
  assign out_if.data.earth_motion_y = e_q[1];
  assign out_if.data.earth_motion_z = e_q[2];

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> !in_fire) else $error("accept while busy");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRot && sub_q == 3'd2 && ri == 2'd2) |=> out_if.valid)
    else $error("result not raised");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> $stable(s_q[0]) && $stable(e_q[2]))
    else $error("result changed while waiting");
endmodule
